// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the light sample smoother.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge outside reset.
`define LSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check on every rising edge, reset included.
`define LSS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== design/lss_pkg.sv =====
// ----------------------------------------------------------------------------
// lss_pkg
// Types, constants and stream field positions of the light sample smoother.
// ----------------------------------------------------------------------------
package lss_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int PCT_W       = 7;
    localparam int PROD_W      = SAMPLE_W + PCT_W;
    localparam int CNT_W       = 4;
    localparam int RUN_W       = 3;
    localparam int ADDR_W      = 3;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    // output tdata field positions
    localparam int SMOOTH_LSB  = 0;
    localparam int ACC_BIT     = SAMPLE_W;
    localparam int PCT_LSB     = SAMPLE_W + 1;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [PCT_W-1:0]    t_pct;

    localparam t_sample          SPIKE_DIST   = 12'd800;
    localparam logic [RUN_W-1:0] SPIKE_LIMIT  = 3'd5;
    localparam t_pct             PCT_TOP      = 7'd100;
    localparam t_pct             PCT_BOTTOM   = 7'd10;
    localparam t_pct             PCT_SPAN     = 7'd90;
    localparam t_sample          CAL_HIGH_RST = 12'hFFF;

    // register index, taken from paddr[2]
    localparam logic REG_CAL_LOW  = 1'b0;
    localparam logic REG_CAL_HIGH = 1'b1;

endpackage

// ===== design/light_sample_smoother.sv =====
// ----------------------------------------------------------------------------
// light_sample_smoother
// Moving-average smoother with spike rejection and inverse brightness map.
// ----------------------------------------------------------------------------
// One sample is worked on at a time. An accepted sample passes the check,
// update and mean states, then the divider for the mean when WINDOW_DEPTH
// is not a power of two, then the percent state and the divider for the
// percent unless the calibration levels are equal or inverted. A rejected
// sample skips the window update and the mean. When the window total and
// mean are both zero, the window is first filled with the sample, one entry
// per cycle, in place of the check, update and mean. A stalled receiver
// holds the finished item in the done state until the output register is
// free. The divider is a one-bit-per-cycle restoring divider shared by the
// mean and the percent map, and the window memory has a single write port.
// A finished result waits in the output register while the next sample is
// taken in.
module light_sample_smoother
    import lss_pkg::*;
#(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // [11:0] sample
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
    // [11:0] smoothed, [12] accepted, [19:13] brightness_pct
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int  SLOT_W     = $clog2(WINDOW_DEPTH);
    localparam int  TOTAL_W    = SAMPLE_W + SLOT_W;
    localparam bit  DEPTH_POW2 = (WINDOW_DEPTH & (WINDOW_DEPTH - 1)) == 0;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FILL  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_UPD   = 3'd3;
    localparam logic [2:0] S_MEAN  = 3'd4;
    localparam logic [2:0] S_PCT   = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    // control state
    logic [2:0]         r_state,    n_state;
    logic [TOTAL_W-1:0] r_total,    n_total;
    t_sample            r_mean,     n_mean;
    logic [SLOT_W-1:0]  r_slot,     n_slot;
    logic [SLOT_W-1:0]  r_fill_idx, n_fill_idx;
    logic [RUN_W-1:0]   r_spike,    n_spike;
    logic [CNT_W-1:0]   r_cnt,      n_cnt;
    logic               r_div_pct,  n_div_pct;
    t_sample            r_cal_low,  n_cal_low;
    t_sample            r_cal_high, n_cal_high;
    logic               r_out_valid, n_out_valid;

    // payload
    t_sample            r_sample,   n_sample;
    logic               r_take,     n_take;
    t_pct               r_pct,      n_pct;
    t_sample            r_rem,      n_rem;
    t_sample            r_shf,      n_shf;
    t_sample            r_den,      n_den;
    t_sample            r_quo,      n_quo;
    t_sample            r_out_smooth, n_out_smooth;
    logic               r_out_acc,  n_out_acc;
    t_pct               r_out_pct,  n_out_pct;

    // window memory
    t_sample            r_win [WINDOW_DEPTH];
    t_sample            r_rd;
    logic               w_we;
    logic [SLOT_W-1:0]  w_waddr;

    logic               w_in_acc;
    logic               w_cfg_wr;
    logic               w_out_load;
    logic [SLOT_W-1:0]  w_slot_inc;
    t_sample            w_dist;
    logic               w_spike;
    logic [RUN_W-1:0]   w_run;
    logic [SAMPLE_W:0]  w_rem2;
    logic               w_ge;
    logic [SAMPLE_W:0]  w_rem_sub;
    t_sample            w_quo;
    t_sample            w_clamp;
    logic [PROD_W-1:0]  w_prod;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign pready        = 1'b1;
    assign w_cfg_wr      = psel && penable && pwrite && pready;
    assign prdata        = (paddr[2] == REG_CAL_HIGH) ? 32'(r_cal_high) : 32'(r_cal_low);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - SAMPLE_W - 1 - PCT_W){1'b0}},
                            r_out_pct, r_out_acc, r_out_smooth};

    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);
    assign w_slot_inc = (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;

    // spike test against the current mean
    assign w_dist  = (r_sample > r_mean) ? r_sample - r_mean : r_mean - r_sample;
    assign w_spike = w_dist > SPIKE_DIST;
    assign w_run   = (r_spike < SPIKE_LIMIT) ? r_spike + 1'b1 : r_spike;

    // one restoring divider step
    assign w_rem2    = {r_rem, r_shf[SAMPLE_W-1]};
    assign w_ge      = w_rem2 >= {1'b0, r_den};
    assign w_rem_sub = w_rem2 - {1'b0, r_den};
    assign w_quo     = {r_quo[SAMPLE_W-2:0], w_ge};

    // clamp the mean to the calibrated range, low bound first
    always_comb begin
        w_clamp = (r_mean < r_cal_low) ? r_cal_low : r_mean;
        if (w_clamp > r_cal_high) begin
            w_clamp = r_cal_high;
        end
    end
    assign w_prod = PROD_W'(w_clamp - r_cal_low) * PROD_W'(PCT_SPAN);

    assign w_we    = (r_state == S_FILL) || (r_state == S_UPD);
    assign w_waddr = (r_state == S_FILL) ? r_fill_idx : r_slot;

    always_comb begin
        n_state      = r_state;
        n_total      = r_total;
        n_mean       = r_mean;
        n_slot       = r_slot;
        n_fill_idx   = r_fill_idx;
        n_spike      = r_spike;
        n_cnt        = r_cnt;
        n_div_pct    = r_div_pct;
        n_cal_low    = r_cal_low;
        n_cal_high   = r_cal_high;
        n_out_valid  = r_out_valid;
        n_sample     = r_sample;
        n_take       = r_take;
        n_pct        = r_pct;
        n_rem        = r_rem;
        n_shf        = r_shf;
        n_den        = r_den;
        n_quo        = r_quo;
        n_out_smooth = r_out_smooth;
        n_out_acc    = r_out_acc;
        n_out_pct    = r_out_pct;

        if (w_cfg_wr) begin
            if (paddr[2] == REG_CAL_LOW) begin
                n_cal_low = pwdata[SAMPLE_W-1:0];
            end else begin
                n_cal_high = pwdata[SAMPLE_W-1:0];
            end
        end

        if (w_out_load) begin
            n_out_valid  = 1'b1;
            n_out_smooth = r_mean;
            n_out_acc    = r_take;
            n_out_pct    = r_pct;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_sample   = s_axis_tdata[SAMPLE_W-1:0];
                    n_fill_idx = '0;
                    n_state    = (r_total == '0 && r_mean == '0) ? S_FILL : S_CHECK;
                end
            end
            S_FILL: begin
                // the total is zero here, so it sums up to sample * depth
                n_total = r_total + TOTAL_W'(r_sample);
                if (r_fill_idx == SLOT_LAST) begin
                    n_mean  = r_sample;
                    n_spike = '0;
                    n_take  = 1'b1;
                    n_slot  = w_slot_inc;
                    n_state = S_PCT;
                end else begin
                    n_fill_idx = r_fill_idx + 1'b1;
                end
            end
            S_CHECK: begin
                if (w_spike) begin
                    n_spike = w_run;
                    n_take  = (w_run == SPIKE_LIMIT);
                end else begin
                    n_spike = '0;
                    n_take  = 1'b1;
                end
                n_state = n_take ? S_UPD : S_PCT;
            end
            S_UPD: begin
                n_total = r_total - TOTAL_W'(r_rd) + TOTAL_W'(r_sample);
                n_slot  = w_slot_inc;
                n_state = S_MEAN;
            end
            S_MEAN: begin
                if (DEPTH_POW2) begin
                    n_mean  = SAMPLE_W'(r_total >> SLOT_W);
                    n_state = S_PCT;
                end else begin
                    // quotient fits 12 bits, so the top bits start as remainder
                    n_rem     = SAMPLE_W'(r_total >> SAMPLE_W);
                    n_shf     = r_total[SAMPLE_W-1:0];
                    n_den     = SAMPLE_W'(WINDOW_DEPTH);
                    n_quo     = '0;
                    n_cnt     = CNT_W'(SAMPLE_W);
                    n_div_pct = 1'b0;
                    n_state   = S_DIV;
                end
            end
            S_PCT: begin
                priority if (r_cal_high == r_cal_low) begin
                    n_pct   = PCT_TOP;
                    n_state = S_DONE;
                end else if (r_cal_low > r_cal_high) begin
                    n_pct   = PCT_BOTTOM;
                    n_state = S_DONE;
                end else begin
                    // quotient stays below 91, so it fits the seven quotient bits
                    n_rem     = w_prod[PROD_W-1 -: SAMPLE_W];
                    n_shf     = {w_prod[PCT_W-1:0], {(SAMPLE_W - PCT_W){1'b0}}};
                    n_den     = r_cal_high - r_cal_low;
                    n_quo     = '0;
                    n_cnt     = CNT_W'(PCT_W);
                    n_div_pct = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = w_ge ? w_rem_sub[SAMPLE_W-1:0] : w_rem2[SAMPLE_W-1:0];
                n_shf = {r_shf[SAMPLE_W-2:0], 1'b0};
                n_quo = w_quo;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    if (r_div_pct) begin
                        n_pct   = PCT_TOP - w_quo[PCT_W-1:0];
                        n_state = S_DONE;
                    end else begin
                        n_mean  = w_quo;
                        n_state = S_PCT;
                    end
                end
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_mean      <= '0;
            r_slot      <= '0;
            r_fill_idx  <= '0;
            r_spike     <= '0;
            r_cnt       <= '0;
            r_div_pct   <= 1'b0;
            r_cal_low   <= '0;
            r_cal_high  <= CAL_HIGH_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_mean      <= n_mean;
            r_slot      <= n_slot;
            r_fill_idx  <= n_fill_idx;
            r_spike     <= n_spike;
            r_cnt       <= n_cnt;
            r_div_pct   <= n_div_pct;
            r_cal_low   <= n_cal_low;
            r_cal_high  <= n_cal_high;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample     <= n_sample;
        r_take       <= n_take;
        r_pct        <= n_pct;
        r_rem        <= n_rem;
        r_shf        <= n_shf;
        r_den        <= n_den;
        r_quo        <= n_quo;
        r_out_smooth <= n_out_smooth;
        r_out_acc    <= n_out_acc;
        r_out_pct    <= n_out_pct;
    end

    // window entries are only read after a fill, so they need no reset
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_win[w_waddr] <= r_sample;
        end
        r_rd <= r_win[r_slot];
    end

endmodule

// ===== design/lss_checker.sv =====
// ----------------------------------------------------------------------------
// lss_checker
// Port-level checks of the light sample smoother, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lss_checker
    import lss_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [OUT_TDATA_W-1:0]  m_axis_tdata
);

    t_sample r_prev_smooth;
    logic    r_prev_ok;
    t_pct    w_pct;
    logic    w_out_acc;

    assign w_pct     = m_axis_tdata[PCT_LSB +: PCT_W];
    assign w_out_acc = m_axis_tvalid && m_axis_tready;

    // remember the average of the last delivered item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_ok <= 1'b0;
        end else if (w_out_acc) begin
            r_prev_ok <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_acc) begin
            r_prev_smooth <= m_axis_tdata[SMOOTH_LSB +: SAMPLE_W];
        end
    end

    `LSS_ASSERT_RST(a_reset_clears_out, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

    `LSS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    `LSS_ASSERT(a_pct_range, m_axis_tvalid |-> (w_pct >= PCT_BOTTOM) && (w_pct <= PCT_TOP), "brightness out of range")

    `LSS_ASSERT(a_reject_keeps_mean, m_axis_tvalid && !m_axis_tdata[ACC_BIT] && r_prev_ok |-> m_axis_tdata[SMOOTH_LSB +: SAMPLE_W] == r_prev_smooth, "rejected item moved the average")

endmodule

bind light_sample_smoother lss_checker u_lss_checker (.*);
